@@ hdl/sllfd_pkg.sv @@
// Shared types and constants for the start/label/length frame deframer.
// No dependencies; the parser, the result register and the top level import this package.
package sllfd_pkg;

    // Register map of the configuration port
    localparam int unsigned CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CfgStartMarker = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgEndMarker   = 1'b1;

    // Reset values of the configuration registers
    localparam logic [7:0] StartMarkerReset = 8'd126;
    localparam logic [7:0] EndMarkerReset   = 8'd231;

    // Payload buffer size: bytes at this offset and beyond are dropped
    localparam logic [15:0] MaxPayload = 16'd600;

    // Result kinds
    localparam logic KindData     = 1'b0;
    localparam logic KindComplete = 1'b1;

    // Parser phases, one-hot
    typedef enum logic [5:0] {
        PhHunt    = 6'b000001,
        PhLabel   = 6'b000010,
        PhLenLo   = 6'b000100,
        PhLenHi   = 6'b001000,
        PhData    = 6'b010000,
        PhWaitEnd = 6'b100000
    } t_phase;

    // One result item
    typedef struct packed {
        logic        kind;
        logic [7:0]  frame_label;
        logic [15:0] position;
        logic [7:0]  payload_byte;
        logic        overflow;
    } t_result;

    // Handoff from the parser to the result register
    typedef struct packed {
        logic    push;
        t_result res;
    } t_push;

endpackage

@@ hdl/sllfd_rx_if.sv @@
// Request channel carrying one received byte.
// Depends on nothing but the clock domain of the block.
interface sllfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hdl/sllfd_res_if.sv @@
// Result channel of the deframer: payload bytes and frame completions.
// Field widths follow the result struct in sllfd_pkg.
interface sllfd_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  frame_label;
    logic [15:0] position;
    logic [7:0]  payload_byte;
    logic        overflow;

    modport source (output valid, output kind, output frame_label, output position,
                    output payload_byte, output overflow, input ready);
    modport sink   (input valid, input kind, input frame_label, input position,
                    input payload_byte, input overflow, output ready);
endinterface

@@ hdl/sllfd_parser.sv @@
// Frame parser: phase register, label, length and offset, one byte per request.
// Uses sllfd_pkg; hands a result to sllfd_out_reg through a t_push struct.
module sllfd_parser
    import sllfd_pkg::*;
#(
    parameter logic [15:0] MAX_PAYLOAD = MaxPayload
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_start_marker,
    input  logic [7:0] i_end_marker,
    output t_push      o_push
);

    t_phase      r_phase,  n_phase;
    logic [7:0]  r_label,  n_label;
    logic [15:0] r_len,    n_len;
    logic [15:0] r_offset, n_offset;
    logic [15:0] len_full;
    logic [15:0] offset_inc;
    t_push       push;

    assign len_full   = {i_rx_byte, r_len[7:0]};
    assign offset_inc = r_offset + 16'd1;

    // Next-state and result decode for the byte being accepted
    always_comb begin
        n_phase  = r_phase;
        n_label  = r_label;
        n_len    = r_len;
        n_offset = r_offset;
        push     = '0;
        case (r_phase)
            PhLabel: begin
                n_label = i_rx_byte;
                n_phase = PhLenLo;
            end
            PhLenLo: begin
                n_offset = '0;
                n_len    = {8'd0, i_rx_byte};
                n_phase  = PhLenHi;
            end
            PhLenHi: begin
                n_len   = len_full;
                n_phase = (len_full == 16'd0) ? PhWaitEnd : PhData;
            end
            PhData: begin
                if (r_offset < MAX_PAYLOAD) begin
                    push.push             = 1'b1;
                    push.res.kind         = KindData;
                    push.res.frame_label  = r_label;
                    push.res.position     = r_offset;
                    push.res.payload_byte = i_rx_byte;
                    push.res.overflow     = 1'b0;
                end
                n_offset = offset_inc;
                if (offset_inc == r_len) begin
                    n_phase = PhWaitEnd;
                end
            end
            PhWaitEnd: begin
                if (i_rx_byte == i_end_marker) begin
                    push.push             = 1'b1;
                    push.res.kind         = KindComplete;
                    push.res.frame_label  = r_label;
                    push.res.position     = r_offset;
                    push.res.payload_byte = 8'd0;
                    push.res.overflow     = (r_len > MAX_PAYLOAD);
                    n_phase               = PhHunt;
                end
            end
            default: begin
                // hunting, and any code that should never be seen
                n_phase = (i_rx_byte == i_start_marker) ? PhLabel : PhHunt;
            end
        endcase
    end

    // State registers advance only on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PhHunt;
            r_label  <= '0;
            r_len    <= '0;
            r_offset <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_label  <= n_label;
            r_len    <= n_len;
            r_offset <= n_offset;
        end
    end

    assign o_push.push = push.push & i_accept;
    assign o_push.res  = push.res;

endmodule

@@ hdl/sllfd_out_reg.sv @@
// Result register: holds one result until the sink takes it.
// Uses sllfd_pkg types; space is free when empty or drained this cycle.
module sllfd_out_reg
    import sllfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_ready,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_space = !r_valid || i_ready;

    // Valid flag: set on a push, cleared when the sink takes the result
    always_comb begin
        n_valid = r_valid && !i_ready;
        if (i_push.push) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_res <= i_push.res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ hdl/start_label_length_frame_deframer.sv @@
// Start/label/length frame deframer, top level.
// A result appears in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle; the single result register stalls input only
// while it holds a result the sink has not taken.
// Reset (synchronous, active low): hunting for start, markers 126 and 231.
module start_label_length_frame_deframer
    import sllfd_pkg::*;
#(
    parameter logic [15:0] MAX_PAYLOAD = MaxPayload
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    sllfd_rx_if.sink           i_rx,
    sllfd_res_if.source        o_res,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [7:0]         i_cfg_data
);

    logic [7:0] r_start_marker;
    logic [7:0] r_end_marker;
    logic       accept;
    logic       space;
    t_push      push;
    t_result    res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= StartMarkerReset;
            r_end_marker   <= EndMarkerReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgStartMarker: r_start_marker <= i_cfg_data;
                CfgEndMarker:   r_end_marker   <= i_cfg_data;
                default: begin
                    r_start_marker <= r_start_marker;
                end
            endcase
        end
    end

    assign i_rx.ready = space;
    assign accept     = i_rx.valid && space;

    sllfd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_rx_byte      (i_rx.rx_byte),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .o_push         (push)
    );

    sllfd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ready (o_res.ready),
        .o_space (space),
        .o_valid (o_res.valid),
        .o_res   (res)
    );

    assign o_res.kind         = res.kind;
    assign o_res.frame_label  = res.frame_label;
    assign o_res.position     = res.position;
    assign o_res.payload_byte = res.payload_byte;
    assign o_res.overflow     = res.overflow;

endmodule
